// File: rtl/core/pair_virial_accumulator_core_assert.svh
// assertion macros for the pair virial accumulator checker
// used by rtl/core/pva_checker.sv, no other dependencies
`ifndef PAIR_VIRIAL_ACCUMULATOR_CORE_ASSERT_SVH
`define PAIR_VIRIAL_ACCUMULATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PVA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pva check failed");

// next-cycle implication, checked outside reset
`define PVA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pva check failed");

`endif

// File: rtl/core/pva_pkg.sv
// shared types, constants and helpers for the pair virial accumulator
// no dependencies
package pva_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int IDX_W         = 10;
  localparam int NCOMP         = 6;
  localparam int ACC_W         = 48;
  localparam int ROW_W         = NCOMP * ACC_W;
  localparam int DIV_STEPS     = 48;
  localparam int CNT_W         = 10;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_RDP   = 2'd1,
    OP_RDG   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_ZERO = 2'd1,
    STS_SAT  = 2'd2
  } sts_t;

  typedef enum logic [1:0] {
    SRC_GLOBAL = 2'd0,
    SRC_ROW    = 2'd1,
    SRC_ZERO   = 2'd2
  } src_t;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_MULP,
    ST_MULV,
    ST_TERM,
    ST_RDI,
    ST_WRI,
    ST_RDJ,
    ST_WRJ,
    ST_RDP,
    ST_CLR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             div_step;
    logic             mul_p;
    logic             mul_v;
    logic             term;
    logic             ram_re;
    logic             ram_we;
    logic             sel_j;
    logic             clr_row;
    logic             clr_glob;
    logic             out_load;
    src_t             out_src;
    logic [2:0]       k;
    logic [1:0]       ps;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic dist_zero;
    logic out_free;
  } stat_t;

  // first displacement axis of each tensor component
  function automatic logic [1:0] comp_a(input logic [2:0] k);
    logic [1:0] a;
    unique case (k)
      3'd0:    a = 2'd0;
      3'd1:    a = 2'd1;
      3'd2:    a = 2'd2;
      3'd3:    a = 2'd1;
      default: a = 2'd0;
    endcase
    return a;
  endfunction

  // second displacement axis of each tensor component
  function automatic logic [1:0] comp_b(input logic [2:0] k);
    logic [1:0] b;
    unique case (k)
      3'd0:    b = 2'd0;
      3'd1:    b = 2'd1;
      3'd2:    b = 2'd2;
      3'd3:    b = 2'd2;
      3'd4:    b = 2'd2;
      default: b = 2'd1;
    endcase
    return b;
  endfunction

  // saturating add, returns {saturated, sum}
  function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] a,
                                              input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return {1'b1, (s[ACC_W] ? ACC_MIN : ACC_MAX)};
    end
    return {1'b0, s[ACC_W-1:0]};
  endfunction

endpackage

// File: rtl/core/pva_ram.sv
// generic single-port ram with registered read
// no dependencies
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/core/pva_ctrl.sv
// controller state machine for the pair virial accumulator
// depends on pva_pkg
module pva_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  pva_pkg::stat_t stat,
  output pva_pkg::cmd_t  cmd
);

  pva_pkg::state_t             state, state_next;
  logic [pva_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic [2:0]                  k, k_next;
  logic [1:0]                  ps, ps_next;

  localparam logic [pva_pkg::CNT_W-1:0] CNT_DIV_LAST = pva_pkg::CNT_W'(pva_pkg::DIV_STEPS - 1);
  localparam logic [pva_pkg::CNT_W-1:0] CNT_ROW_LAST =
    pva_pkg::CNT_W'(pva_pkg::MAX_PARTICLES - 1);
  localparam logic [2:0] K_LAST = 3'(pva_pkg::NCOMP - 1);

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pva_pkg::ST_INIT_CLR;
      cnt   <= '0;
      k     <= '0;
      ps    <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
      ps    <= ps_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pva_pkg::ST_INIT_CLR: if (cnt == CNT_ROW_LAST) state_next = pva_pkg::ST_IDLE;
      pva_pkg::ST_IDLE:     if (item_valid) state_next = pva_pkg::ST_DECODE;
      pva_pkg::ST_DECODE: begin
        unique case (stat.op)
          pva_pkg::OP_ACC: state_next = stat.dist_zero ? pva_pkg::ST_OUT : pva_pkg::ST_DIV;
          pva_pkg::OP_RDP: state_next = pva_pkg::ST_RDP;
          pva_pkg::OP_RDG: state_next = pva_pkg::ST_OUT;
          default:         state_next = pva_pkg::ST_CLR;
        endcase
      end
      pva_pkg::ST_DIV:  if (cnt == CNT_DIV_LAST) state_next = pva_pkg::ST_MULP;
      pva_pkg::ST_MULP: state_next = pva_pkg::ST_MULV;
      pva_pkg::ST_MULV: if (ps == 2'd3) state_next = pva_pkg::ST_TERM;
      pva_pkg::ST_TERM: state_next = (k == K_LAST) ? pva_pkg::ST_RDI : pva_pkg::ST_MULP;
      pva_pkg::ST_RDI:  state_next = pva_pkg::ST_WRI;
      pva_pkg::ST_WRI:  state_next = pva_pkg::ST_RDJ;
      pva_pkg::ST_RDJ:  state_next = pva_pkg::ST_WRJ;
      pva_pkg::ST_WRJ:  state_next = pva_pkg::ST_OUT;
      pva_pkg::ST_RDP:  state_next = pva_pkg::ST_OUT;
      pva_pkg::ST_CLR:  if (cnt == CNT_ROW_LAST) state_next = pva_pkg::ST_OUT;
      pva_pkg::ST_OUT:  if (stat.out_free) state_next = pva_pkg::ST_IDLE;
      default:          state_next = pva_pkg::ST_IDLE;
    endcase
  end

  // counter updates
  always_comb begin
    cnt_next = '0;
    k_next   = k;
    ps_next  = '0;
    unique case (state)
      pva_pkg::ST_INIT_CLR, pva_pkg::ST_CLR, pva_pkg::ST_DIV: cnt_next = cnt + 1'b1;
      pva_pkg::ST_DECODE: k_next  = '0;
      pva_pkg::ST_MULV:   ps_next = ps + 1'b1;
      pva_pkg::ST_TERM:   k_next  = k + 1'b1;
      default: ;
    endcase
  end

  // command outputs
  always_comb begin
    cmd          = '0;
    cmd.out_src  = pva_pkg::SRC_GLOBAL;
    cmd.k        = k;
    cmd.ps       = ps;
    cmd.cnt      = cnt;
    item_stall   = (state != pva_pkg::ST_IDLE);
    unique case (state)
      pva_pkg::ST_INIT_CLR, pva_pkg::ST_CLR: begin
        cmd.clr_row  = 1'b1;
        cmd.clr_glob = 1'b1;
      end
      pva_pkg::ST_IDLE: cmd.load     = item_valid;
      pva_pkg::ST_DIV:  cmd.div_step = 1'b1;
      pva_pkg::ST_MULP: cmd.mul_p    = 1'b1;
      pva_pkg::ST_MULV: cmd.mul_v    = 1'b1;
      pva_pkg::ST_TERM: cmd.term     = 1'b1;
      pva_pkg::ST_RDI, pva_pkg::ST_RDP: cmd.ram_re = 1'b1;
      pva_pkg::ST_WRI:  cmd.ram_we   = 1'b1;
      pva_pkg::ST_RDJ: begin
        cmd.ram_re = 1'b1;
        cmd.sel_j  = 1'b1;
      end
      pva_pkg::ST_WRJ: begin
        cmd.ram_we = 1'b1;
        cmd.sel_j  = 1'b1;
      end
      pva_pkg::ST_OUT: begin
        cmd.out_load = stat.out_free;
        unique case (stat.op)
          pva_pkg::OP_RDP:   cmd.out_src = pva_pkg::SRC_ROW;
          pva_pkg::OP_CLEAR: cmd.out_src = pva_pkg::SRC_ZERO;
          default:           cmd.out_src = pva_pkg::SRC_GLOBAL;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/pva_datapath.sv
// datapath: divider, shared multiplier, global tensor, particle ram, output register
// depends on pva_pkg and pva_ram
module pva_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  pva_pkg::cmd_t                   cmd,
  output pva_pkg::stat_t                  stat,
  input  logic [1:0]                      opcode,
  input  logic signed [31:0]              force_term,
  input  logic [30:0]                     distance,
  input  logic signed [31:0]              disp_x,
  input  logic signed [31:0]              disp_y,
  input  logic signed [31:0]              disp_z,
  input  logic [pva_pkg::IDX_W-1:0]       first_index,
  input  logic [pva_pkg::IDX_W-1:0]       second_index,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic signed [pva_pkg::ACC_W-1:0] comp_xx,
  output logic signed [pva_pkg::ACC_W-1:0] comp_yy,
  output logic signed [pva_pkg::ACC_W-1:0] comp_zz,
  output logic signed [pva_pkg::ACC_W-1:0] comp_yz,
  output logic signed [pva_pkg::ACC_W-1:0] comp_xz,
  output logic signed [pva_pkg::ACC_W-1:0] comp_xy,
  output logic [1:0]                      status
);

  localparam int AW = pva_pkg::ACC_W;

  // captured item
  pva_pkg::op_t                op;
  logic                        f_neg;
  logic [30:0]                 pair_distance;
  logic [31:0]                 disp [3];
  logic [pva_pkg::IDX_W-1:0]   idx_i, idx_j;

  // divider, products and terms
  logic [30:0]     rem;
  logic [47:0]     dnum;
  logic [47:0]     mp;
  logic [95:0]     acc;
  logic [AW-1:0]   half_term [pva_pkg::NCOMP];
  logic [AW-1:0]   glob [pva_pkg::NCOMP];
  logic            sat;

  logic [31:0]     trial;
  logic            q_bit;
  logic [31:0]     da, db, ma, mb;
  logic            neg;
  logic [63:0]     p_prod;
  logic [23:0]     pa, pb;
  logic [47:0]     pp;
  logic [95:0]     pp_sh;
  logic [AW-1:0]   mfull, mhalf, full, half;
  logic            term_sat;
  logic [AW:0]     gsum;
  logic [pva_pkg::ROW_W-1:0] row_q, row_new, ram_wdata;
  logic [pva_pkg::NCOMP-1:0] row_sat;
  logic [pva_pkg::IDX_W-1:0] ram_addr;
  logic [AW:0]     rsum [pva_pkg::NCOMP];

  assign stat.op        = op;
  assign stat.dist_zero = (pair_distance == '0);
  assign stat.out_free  = !result_valid || !result_stall;

  // restoring division step
  assign trial = {rem, dnum[47]};
  assign q_bit = (trial >= {1'b0, pair_distance});

  // component operands as magnitudes
  always_comb begin
    da   = disp[pva_pkg::comp_a(cmd.k)];
    db   = disp[pva_pkg::comp_b(cmd.k)];
    ma   = da[31] ? (32'd0 - da) : da;
    mb   = db[31] ? (32'd0 - db) : db;
    neg  = f_neg ^ da[31] ^ db[31];
    p_prod = 64'(ma) * 64'(mb);
  end

  // partial product of quotient and displacement product
  always_comb begin
    pa = cmd.ps[1] ? dnum[47:24] : dnum[23:0];
    pb = cmd.ps[0] ? mp[47:24] : mp[23:0];
    pp = 48'(pa) * 48'(pb);
    case (cmd.ps)
      2'd0:    pp_sh = 96'(pp);
      2'd3:    pp_sh = 96'(pp) << 48;
      default: pp_sh = 96'(pp) << 24;
    endcase
  end

  // clamp and sign of the full and half terms
  always_comb begin
    term_sat = 1'b0;
    if (|acc[95:63]) begin
      mfull    = pva_pkg::ACC_MAX;
      term_sat = 1'b1;
    end else begin
      mfull = {1'b0, acc[62:16]};
    end
    if (|acc[95:64]) begin
      mhalf    = pva_pkg::ACC_MAX;
      term_sat = 1'b1;
    end else begin
      mhalf = {1'b0, acc[63:17]};
    end
    full = neg ? (AW'(0) - mfull) : mfull;
    half = neg ? (AW'(0) - mhalf) : mhalf;
    gsum = pva_pkg::sat_add(glob[cmd.k], full);
  end

  // particle row update
  always_comb begin
    for (int c = 0; c < pva_pkg::NCOMP; c++) begin
      rsum[c] = pva_pkg::sat_add(row_q[c*AW +: AW], half_term[c]);
      row_new[c*AW +: AW] = rsum[c][AW-1:0];
      row_sat[c] = rsum[c][AW];
    end
    ram_addr  = cmd.clr_row ? cmd.cnt[pva_pkg::IDX_W-1:0] : (cmd.sel_j ? idx_j : idx_i);
    ram_wdata = cmd.clr_row ? '0 : row_new;
  end

  pva_ram #(
    .WIDTH(pva_pkg::ROW_W),
    .DEPTH(pva_pkg::MAX_PARTICLES)
  ) u_row_ram (
    .clk  (clk),
    .we   (cmd.ram_we | cmd.clr_row),
    .re   (cmd.ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(row_q)
  );

  // item capture, divider and multiply sequence
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op            <= pva_pkg::op_t'(opcode);
      f_neg         <= force_term[31];
      pair_distance <= distance;
      disp[0]       <= disp_x;
      disp[1]       <= disp_y;
      disp[2]       <= disp_z;
      idx_i         <= first_index;
      idx_j         <= second_index;
      rem           <= '0;
      dnum          <= {(force_term[31] ? (32'd0 - force_term) : force_term), 16'd0};
      sat           <= 1'b0;
    end
    if (cmd.div_step) begin
      rem  <= q_bit ? 31'(trial - {1'b0, pair_distance}) : trial[30:0];
      dnum <= {dnum[46:0], q_bit};
    end
    if (cmd.mul_p) begin
      mp  <= p_prod[63:16];
      acc <= '0;
    end
    if (cmd.mul_v) begin
      acc <= acc + pp_sh;
    end
    if (cmd.term) begin
      half_term[cmd.k] <= half;
      sat <= sat | term_sat | gsum[AW];
    end
    if (cmd.ram_we) begin
      sat <= sat | (|row_sat);
    end
  end

  // global tensor
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_glob) begin
      for (int c = 0; c < pva_pkg::NCOMP; c++) begin
        glob[c] <= '0;
      end
    end else if (cmd.term) begin
      glob[cmd.k] <= gsum[AW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_src)
        pva_pkg::SRC_ROW: begin
          comp_xx <= row_q[0*AW +: AW];
          comp_yy <= row_q[1*AW +: AW];
          comp_zz <= row_q[2*AW +: AW];
          comp_yz <= row_q[3*AW +: AW];
          comp_xz <= row_q[4*AW +: AW];
          comp_xy <= row_q[5*AW +: AW];
        end
        pva_pkg::SRC_ZERO: begin
          comp_xx <= '0;
          comp_yy <= '0;
          comp_zz <= '0;
          comp_yz <= '0;
          comp_xz <= '0;
          comp_xy <= '0;
        end
        default: begin
          comp_xx <= glob[0];
          comp_yy <= glob[1];
          comp_zz <= glob[2];
          comp_yz <= glob[3];
          comp_xz <= glob[4];
          comp_xy <= glob[5];
        end
      endcase
      if (op == pva_pkg::OP_ACC) begin
        if (pair_distance == '0) begin
          status <= pva_pkg::STS_ZERO;
        end else begin
          status <= sat ? pva_pkg::STS_SAT : pva_pkg::STS_OK;
        end
      end else begin
        status <= pva_pkg::STS_OK;
      end
    end
  end

endmodule

// File: rtl/core/pair_virial_accumulator_core.sv
// Pair virial accumulator: one item at a time. An accumulate runs through these steps:
// capture and decode, the bit-serial divide of force by distance, then for each
// tensor component the shared 32x32 multiplier and 24x24 partial-product unit,
// the read-modify-write of both particle rows in the single-port row ram, and
// loading the result. A clear sweeps all 1024 particle rows one a cycle, and after
// reset the same clearing pass runs before the first item is taken. Result is
// registered, so the next item can be taken while a finished result waits.
// depends on pva_pkg, pva_ctrl, pva_datapath
module pair_virial_accumulator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       opcode,
  input  logic signed [31:0]               force_term,
  input  logic [30:0]                      distance,
  input  logic signed [31:0]               disp_x,
  input  logic signed [31:0]               disp_y,
  input  logic signed [31:0]               disp_z,
  input  logic [pva_pkg::IDX_W-1:0]        first_index,
  input  logic [pva_pkg::IDX_W-1:0]        second_index,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic signed [pva_pkg::ACC_W-1:0] comp_xx,
  output logic signed [pva_pkg::ACC_W-1:0] comp_yy,
  output logic signed [pva_pkg::ACC_W-1:0] comp_zz,
  output logic signed [pva_pkg::ACC_W-1:0] comp_yz,
  output logic signed [pva_pkg::ACC_W-1:0] comp_xz,
  output logic signed [pva_pkg::ACC_W-1:0] comp_xy,
  output logic [1:0]                       status
);

  pva_pkg::cmd_t  cmd;
  pva_pkg::stat_t stat;

  // sequencer
  pva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and storage
  pva_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (opcode),
    .force_term  (force_term),
    .distance    (distance),
    .disp_x      (disp_x),
    .disp_y      (disp_y),
    .disp_z      (disp_z),
    .first_index (first_index),
    .second_index(second_index),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .comp_xx     (comp_xx),
    .comp_yy     (comp_yy),
    .comp_zz     (comp_zz),
    .comp_yz     (comp_yz),
    .comp_xz     (comp_xz),
    .comp_xy     (comp_xy),
    .status      (status)
  );

endmodule

// File: rtl/core/pva_checker.sv
// port-level checks for the pair virial accumulator, bound to the top level
// depends on pair_virial_accumulator_core_assert.svh
`include "pair_virial_accumulator_core_assert.svh"

module pva_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [1:0] status
);

  // a held result stays presented
  `PVA_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
  // no status code beyond saturated
  `PVA_ASSERT_NOW(a_status_code, result_valid, status != 2'd3)
  // clearing pass blocks input right after reset
  `PVA_ASSERT_NOW(a_clear_after_reset, $past(rst), item_stall)
  // one item in flight: a transfer stalls the next cycle
  `PVA_ASSERT_NEXT(a_one_in_flight, item_valid && !item_stall, item_stall)

endmodule

bind pair_virial_accumulator_core pva_checker u_pva_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .status      (status)
);

// File: verif/testbench.sv
// self-checking testbench for pair_virial_accumulator_core
// depends on rtl/core/pva_pkg.sv and the core rtl; predicts each result in a local model
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VIR_MAX = 64'sd140737488355327;
  localparam longint VIR_MIN = -64'sd140737488355328;

  typedef struct {
    logic [pva_pkg::ACC_W-1:0] comp[pva_pkg::NCOMP];
    logic [1:0]                sts;
  } tensor_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] opcode = 2'd0;
  logic signed [31:0] force_term = '0;
  logic [30:0] distance = '0;
  logic signed [31:0] disp_x = '0, disp_y = '0, disp_z = '0;
  logic [pva_pkg::IDX_W-1:0] first_index = '0, second_index = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [pva_pkg::ACC_W-1:0] comp_xx, comp_yy, comp_zz, comp_yz, comp_xz, comp_xy;
  logic [1:0] status;

  // model state of the stores
  longint glob_vir[pva_pkg::NCOMP];
  longint part_vir[pva_pkg::MAX_PARTICLES][pva_pkg::NCOMP];
  tensor_result_t expected_q[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_cycles = 0;

  pair_virial_accumulator_core DUT (.*);

  always #4 clk = ~clk;

  // bounds a term magnitude to the accumulator range
  function automatic longint clamp_term(input logic [63:0] m, input logic neg,
                                        inout logic sat);
    if (m > 64'(VIR_MAX)) begin
      m = 64'(VIR_MAX);
      sat = 1'b1;
    end
    return (neg && m != 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint acc_add(input longint a, input longint b, inout logic sat);
    longint s;
    s = a + b;
    if (s > VIR_MAX) begin
      s = VIR_MAX;
      sat = 1'b1;
    end
    if (s < VIR_MIN) begin
      s = VIR_MIN;
      sat = 1'b1;
    end
    return s;
  endfunction

  function automatic logic [63:0] mag32(input logic signed [31:0] x);
    return x[31] ? 64'd0 - 64'(x) : 64'(x);
  endfunction

  // updates the model stores and returns the expected result of one transfer
  function automatic tensor_result_t compute_virial(input pva_pkg::op_t op,
      input logic signed [31:0] f, input logic [30:0] r, input logic signed [31:0] d[3],
      input int i, input int j);
    tensor_result_t res;
    logic sat;
    logic [63:0] mv, mp, mfull, mhalf;
    logic [127:0] prod;
    logic signed [31:0] da, db;
    logic neg;
    longint full, half;
    int a_ax[pva_pkg::NCOMP] = '{0, 1, 2, 1, 0, 0};
    int b_ax[pva_pkg::NCOMP] = '{0, 1, 2, 2, 2, 1};
    sat = 1'b0;
    res.sts = pva_pkg::STS_OK;
    case (op)
      pva_pkg::OP_CLEAR: begin
        foreach (glob_vir[k]) glob_vir[k] = 0;
        foreach (part_vir[p, k]) part_vir[p][k] = 0;
        foreach (res.comp[k]) res.comp[k] = '0;
        return res;
      end
      pva_pkg::OP_RDP: begin
        foreach (res.comp[k]) res.comp[k] = part_vir[i][k][pva_pkg::ACC_W-1:0];
        return res;
      end
      pva_pkg::OP_RDG: ;
      default: begin
        if (r == 0) begin
          res.sts = pva_pkg::STS_ZERO;
        end else begin
          mv = (mag32(f) << 16) / 64'(r);
          for (int k = 0; k < pva_pkg::NCOMP; k++) begin
            da = d[a_ax[k]];
            db = d[b_ax[k]];
            neg = f[31] ^ da[31] ^ db[31];
            mp = (mag32(da) * mag32(db)) >> 16;
            prod = 128'(mv) * 128'(mp);
            if (prod[127:64] != 0) begin
              mfull = '1;
              mhalf = '1;
            end else begin
              mfull = prod[63:0] >> 16;
              mhalf = prod[63:0] >> 17;
            end
            full = clamp_term(mfull, neg, sat);
            half = clamp_term(mhalf, neg, sat);
            glob_vir[k] = acc_add(glob_vir[k], full, sat);
            part_vir[i][k] = acc_add(part_vir[i][k], half, sat);
            part_vir[j][k] = acc_add(part_vir[j][k], half, sat);
          end
          res.sts = sat ? pva_pkg::STS_SAT : pva_pkg::STS_OK;
        end
      end
    endcase
    foreach (res.comp[k]) res.comp[k] = glob_vir[k][pva_pkg::ACC_W-1:0];
    return res;
  endfunction

  // offers one item until transferred, then idles at random
  task automatic send_item(input pva_pkg::op_t op, input logic signed [31:0] f,
      input logic [30:0] r, input logic signed [31:0] dx, input logic signed [31:0] dy,
      input logic signed [31:0] dz, input int i, input int j);
    logic signed [31:0] d[3];
    d = '{dx, dy, dz};
    item_valid <= 1'b1;
    opcode <= op;
    force_term <= f;
    distance <= r;
    disp_x <= dx;
    disp_y <= dy;
    disp_z <= dz;
    first_index <= i[pva_pkg::IDX_W-1:0];
    second_index <= j[pva_pkg::IDX_W-1:0];
    do @(posedge clk); while (item_stall);
    expected_q.push_back(compute_virial(op, f, r, d, i, j));
    if ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      result_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    tensor_result_t exp_r;
    logic [pva_pkg::ACC_W-1:0] got[pva_pkg::NCOMP];
    if (!rst && result_valid && !result_stall) begin
      got = '{comp_xx, comp_yy, comp_zz, comp_yz, comp_xz, comp_xy};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transfer, comp_xx %h", $time, comp_xx);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        foreach (got[k])
          if (got[k] !== exp_r.comp[k]) begin
            $display("%0t: component %0d expected %h actual %h", $time, k,
                     exp_r.comp[k], got[k]);
            errors++;
          end
        if (status !== exp_r.sts) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.sts, status);
          errors++;
        end
      end
    end
  end

  // signed value with a random magnitude scale
  function automatic logic signed [31:0] rand_q16();
    logic [31:0] v;
    v = $urandom() >> $urandom_range(31);
    return ($urandom_range(1) != 0) ? -v : v;
  endfunction

  task automatic test_directed();
    send_item(pva_pkg::OP_RDG, 0, 0, 0, 0, 0, 0, 0);
    send_item(pva_pkg::OP_ACC, 32'sh0001_0000, 31'h0001_0000, 32'sh0002_0000,
              32'sh0003_0000, -32'sh0001_8000, 5, 9);
    send_item(pva_pkg::OP_RDP, 0, 0, 0, 0, 0, 5, 0);
    send_item(pva_pkg::OP_RDP, 0, 0, 0, 0, 0, 9, 0);
    // zero distance leaves everything untouched
    send_item(pva_pkg::OP_ACC, 32'sh0004_0000, 0, 32'sh0001_0000, 32'sh0001_0000,
              32'sh0001_0000, 5, 9);
    // same particle twice
    send_item(pva_pkg::OP_ACC, -32'sh0002_0000, 31'h0000_8000, 32'sh0001_0000,
              -32'sh0000_4000, 32'sh0000_2000, 7, 7);
    send_item(pva_pkg::OP_RDP, 0, 0, 0, 0, 0, 7, 0);
    // extreme fields, saturating terms and accumulators
    send_item(pva_pkg::OP_ACC, 32'h8000_0000, 31'd1, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 0, 1023);
    send_item(pva_pkg::OP_ACC, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 1023, 0);
    send_item(pva_pkg::OP_ACC, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 1023, 1023);
    send_item(pva_pkg::OP_RDP, 0, 0, 0, 0, 0, 1023, 0);
    send_item(pva_pkg::OP_RDP, 0, 0, 0, 0, 0, 0, 0);
    send_item(pva_pkg::OP_ACC, 32'sd1, 31'h7fff_ffff, 32'sd1, 32'sd1, 32'sd1, 3, 4);
    send_item(pva_pkg::OP_ACC, 0, 31'h0001_0000, 32'hffff_ffff, 32'h5555_5555,
              32'haaaa_aaaa, 3, 4);
    send_item(pva_pkg::OP_RDG, 0, 0, 0, 0, 0, 0, 0);
    send_item(pva_pkg::OP_CLEAR, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 1023, 1023);
    send_item(pva_pkg::OP_RDP, 0, 0, 0, 0, 0, 1023, 0);
    send_item(pva_pkg::OP_RDG, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int count, input int tx_pct, input int rx_pct);
    int sel, i, j;
    logic [30:0] r;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      sel = $urandom_range(199);
      i = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15);
      j = ($urandom_range(7) == 0) ? i
          : (($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15));
      r = ($urandom_range(19) == 0) ? 31'd0 : 31'($urandom() >> $urandom_range(1, 31));
      if (r == 0 && $urandom_range(1) != 0) r = 31'd1;
      if (sel < 2)
        send_item(pva_pkg::OP_CLEAR, rand_q16(), r, rand_q16(), rand_q16(), rand_q16(),
                  i, j);
      else if (sel < 30)
        send_item(pva_pkg::OP_RDP, rand_q16(), r, rand_q16(), rand_q16(), rand_q16(), i, j);
      else if (sel < 50)
        send_item(pva_pkg::OP_RDG, rand_q16(), r, rand_q16(), rand_q16(), rand_q16(), i, j);
      else
        send_item(pva_pkg::OP_ACC, rand_q16(), r, rand_q16(), rand_q16(), rand_q16(), i, j);
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_cycles <= 600;
    repeat (6) send_item(pva_pkg::OP_ACC, rand_q16(), 31'h0000_4000, rand_q16(), rand_q16(),
                         rand_q16(), $urandom_range(15), $urandom_range(15));
    send_item(pva_pkg::OP_RDG, 0, 0, 0, 0, 0, 0, 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(370, 14, 82);
    test_random(370, 82, 14);
    test_backpressure();
    test_random(370, 0, 0);
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
